// ===== src/grc_pkg.sv =====
package grc_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 15;

    localparam int OUT_W = FRAC_BITS + 1;
    localparam int MAG_W = IN_WIDTH;
    localparam int SQ_W  = 2 * IN_WIDTH - 1;
    localparam int R2_W  = 2 * IN_WIDTH;
    localparam int T_W   = FRAC_BITS + 1;
    localparam int Q_W   = T_W + R2_W;
    localparam int REM_W = SQ_W + 2 * FRAC_BITS + 2;
    localparam int D_W   = REM_W + 2;
    localparam int BIT_W = $clog2(FRAC_BITS + 1);
    localparam int N_ITER = FRAC_BITS + 1;

    typedef logic signed [IN_WIDTH-1:0] t_in_val;
    typedef logic signed [OUT_W-1:0]    t_out_val;

    typedef struct packed {
        logic              valid;
        logic [R2_W-1:0]   r2;
        logic [REM_W-1:0]  rem_c;
        logic [Q_W-1:0]    q_c;
        logic [T_W-1:0]    t_c;
        logic [REM_W-1:0]  rem_s;
        logic [Q_W-1:0]    q_s;
        logic [T_W-1:0]    t_s;
        logic              zero_z;
        logic              swap;
        logic              same_sign;
    } t_stage;

endpackage

// ===== src/grc_if.sv =====
interface grc_in_if;
    logic                 valid;
    logic                 ready;
    grc_pkg::t_in_val     x_in;
    grc_pkg::t_in_val     z_in;

    modport source (output valid, output x_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input z_in, output ready);
endinterface

interface grc_out_if;
    logic                 valid;
    logic                 ready;
    grc_pkg::t_out_val    cos_val;
    grc_pkg::t_out_val    sin_val;

    modport source (output valid, output cos_val, output sin_val, input ready);
    modport sink   (input valid, input cos_val, input sin_val, output ready);
endinterface

// ===== src/grc_root_step.sv =====
module grc_root_step (
    input  logic [grc_pkg::REM_W-1:0] i_rem,
    input  logic [grc_pkg::Q_W-1:0]   i_q,
    input  logic [grc_pkg::T_W-1:0]   i_t,
    input  logic [grc_pkg::R2_W-1:0]  i_r2,
    input  logic [grc_pkg::BIT_W-1:0] i_bit,
    output logic [grc_pkg::REM_W-1:0] o_rem,
    output logic [grc_pkg::Q_W-1:0]   o_q,
    output logic [grc_pkg::T_W-1:0]   o_t
);
    import grc_pkg::*;

    logic [D_W-1:0]   qd;
    logic [D_W-1:0]   rd;
    logic [D_W-1:0]   d;
    logic [D_W-1:0]   rem_ext;
    logic [BIT_W:0]   sh_q;
    logic [BIT_W:0]   sh_r;
    logic             take;

    // Trial of one more result bit: (t + 2^b)^2 * r2 - t^2 * r2 = 2^(b+1)*t*r2 + 2^(2b)*r2,
    // with t*r2 kept in q so that no multiplier is needed here.
    always_comb begin
        sh_q    = {1'b0, i_bit} + (BIT_W+1)'(1);
        sh_r    = {i_bit, 1'b0};
        qd      = D_W'(i_q) << sh_q;
        rd      = D_W'(i_r2) << sh_r;
        d       = qd + rd;
        rem_ext = D_W'(i_rem);
        take    = (d <= rem_ext);
        o_rem   = take ? REM_W'(rem_ext - d) : i_rem;
        o_q     = take ? i_q + (Q_W'(i_r2) << i_bit) : i_q;
        o_t     = take ? (i_t | (T_W'(1) << i_bit)) : i_t;
    end
endmodule

// ===== src/givens_rotation_coefficients.sv =====
// Channel   Dir  Handshake     Payload
// i_pair    in   valid/ready   x_in, z_in   (signed integers)
// o_coef    out  valid/ready   cos_val, sin_val (signed Q1.15)
//
// One pair enters every cycle while i_pair is ready; each result, once its pair
// is taken, passes through three setup stages (magnitudes, squares, radicand), one stage per
// result bit of the root-ratio search (16), and the output register.
// Reset (synchronous, active low) clears the valid bits and the skid stage.
// A stall at the output fills a one-entry skid stage; only then does i_pair
// drop ready, and the whole pipeline holds until it drains.
module givens_rotation_coefficients (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grc_in_if.sink    i_pair,
    grc_out_if.source o_coef
);
    import grc_pkg::*;

    logic [MAG_W-1:0] n_ax, n_az;
    logic [MAG_W-1:0] r_ax, r_az;
    logic             r_v1, r_zz1, r_sw1, r_ss1;

    logic [SQ_W-1:0]  r_sqx, r_sqz;
    logic             r_v2, r_zz2, r_sw2, r_ss2;

    t_stage           r_st [0:N_ITER];
    t_stage           n_st [1:N_ITER];

    logic             ce;
    logic             push;
    t_out_val         n_cos, n_sin;
    t_out_val         r_out_cos, r_out_sin, r_skid_cos, r_skid_sin;
    logic             r_out_v, r_skid_v;

    function automatic t_out_val enc(input logic [T_W-1:0] t, input logic neg);
        logic [T_W:0]       sum;
        logic [T_W-1:0]     q;
        logic [OUT_W-1:0]   mag;
        sum = {1'b0, t} + (T_W+1)'(1);
        q   = sum[T_W:1];
        if (q >= (T_W'(1) << FRAC_BITS)) begin
            mag = (OUT_W'(1) << FRAC_BITS) - OUT_W'(1);
        end else begin
            mag = OUT_W'(q);
        end
        enc = (neg && (mag != '0)) ? t_out_val'(-mag) : t_out_val'(mag);
    endfunction

    assign ce           = !r_skid_v;
    assign i_pair.ready = ce;

    always_comb begin
        n_ax = i_pair.x_in[IN_WIDTH-1] ? MAG_W'(-i_pair.x_in) : MAG_W'(i_pair.x_in);
        n_az = i_pair.z_in[IN_WIDTH-1] ? MAG_W'(-i_pair.z_in) : MAG_W'(i_pair.z_in);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ax  <= n_ax;
            r_az  <= n_az;
            r_zz1 <= (i_pair.z_in == '0);
            r_sw1 <= (n_az > n_ax);
            r_ss1 <= (i_pair.x_in[IN_WIDTH-1] == i_pair.z_in[IN_WIDTH-1]);

            r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_sqz <= SQ_W'(r_az) * SQ_W'(r_az);
            r_zz2 <= r_zz1;
            r_sw2 <= r_sw1;
            r_ss2 <= r_ss1;

            r_st[0].r2        <= R2_W'(r_sqx) + R2_W'(r_sqz);
            r_st[0].rem_c     <= REM_W'(r_sqx) << (2 * FRAC_BITS + 2);
            r_st[0].rem_s     <= REM_W'(r_sqz) << (2 * FRAC_BITS + 2);
            r_st[0].q_c       <= '0;
            r_st[0].q_s       <= '0;
            r_st[0].t_c       <= '0;
            r_st[0].t_s       <= '0;
            r_st[0].zero_z    <= r_zz2;
            r_st[0].swap      <= r_sw2;
            r_st[0].same_sign <= r_ss2;
        end
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_st[0].valid <= 1'b0;
        end else if (ce) begin
            r_v1          <= i_pair.valid;
            r_v2          <= r_v1;
            r_st[0].valid <= r_v2;
        end
    end

    for (genvar k = 0; k < N_ITER; k++) begin : g_iter
        localparam logic [BIT_W-1:0] BitIdx = BIT_W'(FRAC_BITS - k);

        grc_root_step u_cos (
            .i_rem (r_st[k].rem_c),
            .i_q   (r_st[k].q_c),
            .i_t   (r_st[k].t_c),
            .i_r2  (r_st[k].r2),
            .i_bit (BitIdx),
            .o_rem (n_st[k+1].rem_c),
            .o_q   (n_st[k+1].q_c),
            .o_t   (n_st[k+1].t_c)
        );

        grc_root_step u_sin (
            .i_rem (r_st[k].rem_s),
            .i_q   (r_st[k].q_s),
            .i_t   (r_st[k].t_s),
            .i_r2  (r_st[k].r2),
            .i_bit (BitIdx),
            .o_rem (n_st[k+1].rem_s),
            .o_q   (n_st[k+1].q_s),
            .o_t   (n_st[k+1].t_s)
        );

        assign n_st[k+1].valid     = r_st[k].valid;
        assign n_st[k+1].r2        = r_st[k].r2;
        assign n_st[k+1].zero_z    = r_st[k].zero_z;
        assign n_st[k+1].swap      = r_st[k].swap;
        assign n_st[k+1].same_sign = r_st[k].same_sign;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1].valid <= 1'b0;
            end else if (ce) begin
                r_st[k+1].valid <= n_st[k+1].valid;
            end
            if (ce) begin
                r_st[k+1].r2        <= n_st[k+1].r2;
                r_st[k+1].rem_c     <= n_st[k+1].rem_c;
                r_st[k+1].q_c       <= n_st[k+1].q_c;
                r_st[k+1].t_c       <= n_st[k+1].t_c;
                r_st[k+1].rem_s     <= n_st[k+1].rem_s;
                r_st[k+1].q_s       <= n_st[k+1].q_s;
                r_st[k+1].t_s       <= n_st[k+1].t_s;
                r_st[k+1].zero_z    <= n_st[k+1].zero_z;
                r_st[k+1].swap      <= n_st[k+1].swap;
                r_st[k+1].same_sign <= n_st[k+1].same_sign;
            end
        end
    end

    // The larger component (x on a tie) keeps a positive coefficient; the other one
    // takes the minus sign when x and z share a sign.
    always_comb begin
        if (r_st[N_ITER].zero_z) begin
            n_cos = t_out_val'((OUT_W'(1) << FRAC_BITS) - OUT_W'(1));
            n_sin = '0;
        end else begin
            n_cos = enc(r_st[N_ITER].t_c, r_st[N_ITER].swap && r_st[N_ITER].same_sign);
            n_sin = enc(r_st[N_ITER].t_s, !r_st[N_ITER].swap && r_st[N_ITER].same_sign);
        end
    end

    assign push = ce && r_st[N_ITER].valid;

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_coef.ready) begin
            r_out_cos <= r_skid_v ? r_skid_cos : n_cos;
            r_out_sin <= r_skid_v ? r_skid_sin : n_sin;
        end else if (push) begin
            r_skid_cos <= n_cos;
            r_skid_sin <= n_sin;
        end
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_coef.ready) begin
            r_out_v  <= r_skid_v || push;
            r_skid_v <= 1'b0;
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    assign o_coef.valid   = r_out_v;
    assign o_coef.cos_val = r_out_cos;
    assign o_coef.sin_val = r_out_sin;
endmodule

// ===== src/grc_checker.sv =====
module grc_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [grc_pkg::OUT_W-1:0] i_cos,
    input logic [grc_pkg::OUT_W-1:0] i_sin
);
    import grc_pkg::*;

    // A result never carries two negative coefficients.
    a_one_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_cos[OUT_W-1] && i_sin[OUT_W-1]))
        else $error("both coefficients negative");

    // The larger magnitude is at least 1/sqrt(2), so both cannot be zero.
    a_not_both_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !((i_cos == '0) && (i_sin == '0)))
        else $error("both coefficients zero");

    // Input side backs off only when a result is held at the output.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled without a pending result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_cos) && $stable(i_sin)))
        else $error("stalled result changed");
endmodule

bind givens_rotation_coefficients grc_checker u_grc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_coef.valid),
    .i_out_ready (o_coef.ready),
    .i_cos       (o_coef.cos_val),
    .i_sin       (o_coef.sin_val)
);
